>>> sv/assert_macros.svh
// Assertion macros used by the tokenizer RTL.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define CST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> sv/cst_pkg.sv
// Shared types and constants for the character stream tokenizer.
// No dependencies; used by cst_scan and char_stream_tokenizer.
package cst_pkg;

  localparam int MAX_TOKEN_CHARS = 8;
  localparam int TEXT_W          = 64;
  localparam int FIFO_DEPTH      = 4;

  // Keyword texts, first character in the lowest byte
  localparam logic [TEXT_W-1:0] TEXT_LET   = 64'h0000_0000_0074_656C;
  localparam logic [TEXT_W-1:0] TEXT_CONST = 64'h0000_0074_736E_6F63;

  typedef enum logic [3:0] {
    KIND_BINOP    = 4'd0,
    KIND_BANG     = 4'd1,
    KIND_QUESTION = 4'd2,
    KIND_OPEN     = 4'd3,
    KIND_CLOSE    = 4'd4,
    KIND_IDENT    = 4'd5,
    KIND_LET      = 4'd6,
    KIND_CONST    = 4'd7,
    KIND_NUMBER   = 4'd8,
    KIND_ERROR    = 4'd9
  } kind_e;

  // One result token
  typedef struct packed {
    kind_e             kind;
    logic [TEXT_W-1:0] text;
    logic [3:0]        len;
    logic              cut;
    logic              last;
  } tok_t;

endpackage

>>> sv/cst_scan.sv
// Scanner core: run state registers and per-item token generation.
// Depends on cst_pkg; emits up to two tokens for each consumed item.
module cst_scan import cst_pkg::*; #(
  parameter int MaxTokenChars = MAX_TOKEN_CHARS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  logic [7:0]     char_i,
  input  logic           eos_i,
  output tok_t [1:0]     toks_o,
  output logic [1:0]     tok_cnt_o
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_HALT   = 2'd3
  } mode_e;

  localparam logic [3:0] MaxLen = 4'(MaxTokenChars);
  localparam logic [7:0] CharCr = 8'h0D;

  mode_e             mode_q, mode_d;
  logic [TEXT_W-1:0] text_q, text_d;
  logic [3:0]        len_q, len_d;
  logic              cut_q, cut_d;

  // Token for a pending run; keyword only on exact, uncut match
  function automatic tok_t run_tok(mode_e m, logic [TEXT_W-1:0] t, logic [3:0] l,
                                   logic ct);
    tok_t r;
    r      = '0;
    r.text = t;
    r.len  = l;
    if (m == MODE_NUMBER) begin
      r.kind = KIND_NUMBER;
    end else begin
      r.cut = ct;
      if (!ct && l == 4'd3 && t == TEXT_LET) begin
        r.kind = KIND_LET;
      end else if (!ct && l == 4'd5 && t == TEXT_CONST) begin
        r.kind = KIND_CONST;
      end else begin
        r.kind = KIND_IDENT;
      end
    end
    return r;
  endfunction

  // Per-item next state and tokens
  always_comb begin
    mode_e             m;
    logic [TEXT_W-1:0] t;
    logic [3:0]        l;
    logic              ct;
    logic              letter, digit, flush;
    tok_t              tok_a, tok_b;
    logic              a_vld, b_vld;

    letter = (char_i >= "A" && char_i <= "Z") || (char_i >= "a" && char_i <= "z");
    digit  = (char_i >= "0" && char_i <= "9");
    m      = mode_q;
    t      = text_q;
    l      = len_q;
    ct     = cut_q;
    tok_a  = '0;
    tok_b  = '0;
    a_vld  = 1'b0;
    b_vld  = 1'b0;
    flush  = 1'b0;

    if (mode_q == MODE_HALT) begin
      if (eos_i) begin
        m  = MODE_IDLE;
        t  = '0;
        l  = '0;
        ct = 1'b0;
      end
    end else begin
      if (letter) begin
        flush = (mode_q != MODE_IDENT);
      end else if (digit) begin
        flush = (mode_q != MODE_NUMBER) || (len_q >= MaxLen);
      end else begin
        flush = 1'b1;
      end

      // Emit the pending run when this character does not continue it
      if (flush) begin
        a_vld = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
        tok_a = run_tok(mode_q, text_q, len_q, cut_q);
        m     = MODE_IDLE;
        t     = '0;
        l     = '0;
        ct    = 1'b0;
      end

      if (letter || digit) begin
        // Append into the next free byte lane, or mark the run cut
        m = letter ? MODE_IDENT : MODE_NUMBER;
        if (l < MaxLen) begin
          for (int i = 0; i < 8; i++) begin
            if (l == 4'(i)) begin
              t[8*i +: 8] = char_i;
            end
          end
          l = l + 4'd1;
        end else begin
          ct = 1'b1;
        end
      end else begin
        tok_b.text = {{(TEXT_W-8){1'b0}}, char_i};
        tok_b.len  = 4'd1;
        case (char_i)
          " ", "\t", CharCr, "\n": begin
          end
          "+", "-", "*", "/": begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_BINOP;
          end
          "!": begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_BANG;
          end
          "?": begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_QUESTION;
          end
          "(": begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_OPEN;
          end
          ")": begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_CLOSE;
          end
          8'h00: begin
            m = MODE_HALT;
          end
          default: begin
            b_vld      = 1'b1;
            tok_b.kind = KIND_ERROR;
            m          = MODE_HALT;
          end
        endcase
      end

      // End of source: flush whatever run is left, return to idle
      if (eos_i) begin
        if (m == MODE_IDENT || m == MODE_NUMBER) begin
          b_vld = 1'b1;
          tok_b = run_tok(m, t, l, ct);
        end
        m  = MODE_IDLE;
        t  = '0;
        l  = '0;
        ct = 1'b0;
      end
    end

    mode_d = m;
    text_d = t;
    len_d  = l;
    cut_d  = ct;

    // Compact the two slots and mark the final token of the item
    toks_o    = '0;
    tok_cnt_o = 2'd0;
    if (item_valid_i) begin
      if (a_vld && b_vld) begin
        toks_o[0]      = tok_a;
        toks_o[1]      = tok_b;
        toks_o[1].last = 1'b1;
        tok_cnt_o      = 2'd2;
      end else if (a_vld) begin
        toks_o[0]      = tok_a;
        toks_o[0].last = 1'b1;
        tok_cnt_o      = 2'd1;
      end else if (b_vld) begin
        toks_o[0]      = tok_b;
        toks_o[0].last = 1'b1;
        tok_cnt_o      = 2'd1;
      end
    end
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      text_q <= '0;
      len_q  <= '0;
      cut_q  <= 1'b0;
    end else if (item_valid_i) begin
      mode_q <= mode_d;
      text_q <= text_d;
      len_q  <= len_d;
      cut_q  <= cut_d;
    end
  end

endmodule

>>> sv/char_stream_tokenizer.sv
// Usage
//   Input channel s_axis: one source byte per item in s_axis_tdata[7:0];
//   s_axis_tlast marks the last byte of the source text.
//   Output channel m_axis: one token per item. m_axis_tuser carries the token
//   kind, m_axis_tdata the text, length and truncation flag, and m_axis_tlast
//   marks the last token caused by one input byte.
// Timing
//   A byte accepted into the input register is scanned from there, and its
//   tokens (zero, one or two) enter a four-entry token queue, whose head
//   drives the output channel.
//   One byte per cycle is taken as long as the queue holds at most two
//   tokens; the output port carries a single token, so the two tokens of
//   one byte leave it one after the other.
// Reset
//   Asynchronous, active low. The scanner returns to idle with no run
//   pending, and the input register and token queue are emptied.
// Stalls
//   When m_axis_tready is low, tokens collect in the queue; once it is
//   above half full the input register holds its byte and s_axis_tready drops.
// Depends on cst_pkg, cst_scan and assert_macros.svh.
`include "assert_macros.svh"

module char_stream_tokenizer import cst_pkg::*; #(
  parameter int MaxTokenChars = MAX_TOKEN_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_char
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] token_text, [67:64] token_length,
                                      // [68] text_truncated, [71:69] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast    // last_of_byte
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  // Input register
  logic       stage_vld_q, stage_vld_d;
  logic [7:0] stage_char_q;
  logic       stage_eos_q;
  logic       s_acc, room, consume;

  // Token queue
  tok_t            fifo_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  tok_t [1:0] toks;
  logic [1:0] tok_cnt;
  tok_t       head;

  assign room          = cnt_q <= CntW'(FIFO_DEPTH - 2);
  assign consume       = stage_vld_q && room;
  assign s_axis_tready = !stage_vld_q || consume;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign stage_vld_d   = s_acc || (stage_vld_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      stage_char_q <= s_axis_tdata;
      stage_eos_q  <= s_axis_tlast;
    end
  end

  cst_scan #(
    .MaxTokenChars(MaxTokenChars)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(consume),
    .char_i      (stage_char_q),
    .eos_i       (stage_eos_q),
    .toks_o      (toks),
    .tok_cnt_o   (tok_cnt)
  );

  // Queue pointers and fill count
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_d = wr_ptr_q + PtrW'(tok_cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(tok_cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (tok_cnt != 2'd0) begin
      fifo_q[wr_ptr_q] <= toks[0];
    end
    if (tok_cnt == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= toks[1];
    end
  end

  // Output from queue head
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {3'b000, head.cut, head.len, head.text};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  `CST_ASSERT(a_cnt_bound, cnt_q <= CntW'(FIFO_DEPTH), "token queue count above depth")
  `CST_ASSERT_NEVER(a_tok_cnt, tok_cnt == 2'd3, "scanner reported three tokens")
  `CST_ASSERT_NEVER(a_idle_push, !consume && tok_cnt != 2'd0, "tokens without a consumed item")
  `CST_ASSERT(a_two_last, tok_cnt == 2'd2 |-> toks[1].last && !toks[0].last, "bad last mark")
  `CST_ASSERT(a_one_last, tok_cnt == 2'd1 |-> toks[0].last, "single token not marked last")

endmodule

>>> tb/sv/tb_char_stream_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for char_stream_tokenizer: streams source bytes in,
// predicts every token with a scanner model of its own and checks the tokens out.
// Depends on cst_pkg and the char_stream_tokenizer RTL.
module tb_char_stream_tokenizer;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 500;
  localparam int CALM_ITEMS    = 50;   // final stretch with no idling
  localparam int LONG_HOLD     = 300;  // receiver hold-off, in cycles
  localparam int HOLD_AT_TOKEN = 60;   // token count that starts the hold-off
  localparam int DRAIN_SOURCE  = 12;   // random source that waits for a drained queue
  localparam int TAIL_CYCLES   = 10;   // latency allowance at the end
  localparam int MAX_REPORTS   = 10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] OP_CHARS [8]    = '{"+", "-", "*", "/", "!", "?", "(", ")"};
  localparam logic [7:0] BLANK_CHARS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  localparam logic [7:0] ODD_CHARS [8]   = '{"#", "=", ";", "@", "~", ".", 8'h01, 8'h7F};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_HALT} scan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       drain_first;  // hold this item until no token is outstanding
  } src_item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  char_stream_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner state of the predictor
  scan_e       scan_state;
  logic [63:0] held_text;
  logic [3:0]  held_len;
  logic        held_cut;

  tok_t        expected_tokens [$];
  tok_t        byte_tokens [$];
  src_item_t   pending_items [$];
  src_item_t   next_item;
  string       keyword_like [6] = '{"let", "const", "le", "cons", "lets", "Let"};

  int items_total;
  int items_accepted;
  int random_items;
  int sources_made;
  int gap_left;
  int stall_left;
  int hold_left;
  int tokens_seen;
  int mismatches;
  int cycle_count;
  logic calm;

  function automatic void queue_token(kind_e k, logic [63:0] text, logic [3:0] len,
                                      logic cut);
    tok_t t;
    t.kind = k;
    t.text = text;
    t.len  = len;
    t.cut  = cut;
    t.last = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void drop_run();
    scan_state = SCAN_IDLE;
    held_text  = '0;
    held_len   = '0;
    held_cut   = 1'b0;
  endfunction

  // Emit the pending identifier or number, then go idle
  function automatic void emit_pending_run();
    kind_e k;
    if (scan_state == SCAN_IDENT) begin
      k = KIND_IDENT;
      if (!held_cut && held_len == 4'd3 && held_text == TEXT_LET) k = KIND_LET;
      else if (!held_cut && held_len == 4'd5 && held_text == TEXT_CONST) k = KIND_CONST;
      queue_token(k, held_text, held_len, held_cut);
    end else if (scan_state == SCAN_NUMBER) begin
      queue_token(KIND_NUMBER, held_text, held_len, 1'b0);
    end
    drop_run();
  endfunction

  function automatic void add_run_char(scan_e mode, logic [7:0] c);
    if (scan_state != mode) drop_run();
    scan_state = mode;
    if (held_len < MAX_TOKEN_CHARS) begin
      held_text[held_len*8 +: 8] = c;
      held_len++;
    end else begin
      held_cut = 1'b1;
    end
  endfunction

  // Expected tokens for one accepted source byte
  function automatic void predict_byte(logic [7:0] c, logic eos);
    logic is_letter;
    logic is_digit;
    byte_tokens.delete();
    if (scan_state == SCAN_HALT) begin
      if (eos) drop_run();
      return;
    end
    is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    is_digit  = (c >= "0" && c <= "9");
    if (is_letter) begin
      if (scan_state != SCAN_IDENT) emit_pending_run();
      add_run_char(SCAN_IDENT, c);
    end else if (is_digit) begin
      // a full number splits before the new digit
      if (scan_state != SCAN_NUMBER || held_len >= MAX_TOKEN_CHARS) emit_pending_run();
      add_run_char(SCAN_NUMBER, c);
    end else begin
      emit_pending_run();
      case (c)
        CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
        "+", "-", "*", "/": queue_token(KIND_BINOP, 64'(c), 4'd1, 1'b0);
        "!": queue_token(KIND_BANG, 64'(c), 4'd1, 1'b0);
        "?": queue_token(KIND_QUESTION, 64'(c), 4'd1, 1'b0);
        "(": queue_token(KIND_OPEN, 64'(c), 4'd1, 1'b0);
        ")": queue_token(KIND_CLOSE, 64'(c), 4'd1, 1'b0);
        CH_NUL: scan_state = SCAN_HALT;
        default: begin
          queue_token(KIND_ERROR, 64'(c), 4'd1, 1'b0);
          scan_state = SCAN_HALT;
        end
      endcase
    end
    if (eos) begin
      if (scan_state == SCAN_HALT) drop_run();
      else emit_pending_run();
    end
    if (byte_tokens.size() > 0) byte_tokens[$].last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // Stimulus building
  function automatic void push_byte(logic [7:0] c, logic eos, logic counts);
    src_item_t it;
    it.ch          = c;
    it.eos         = eos;
    it.drain_first = 1'b0;
    pending_items.push_back(it);
    if (counts) random_items++;
  endfunction

  function automatic void push_text(string s, logic counts);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0, counts);
  endfunction

  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
  endfunction

  // One random source text, ended by an item with end of source set
  function automatic void add_source();
    int parts;
    int len;
    int pick;
    int first;
    logic [7:0] c;
    parts = $urandom_range(2, 10);
    first = pending_items.size();
    for (int p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_text(keyword_like[$urandom_range(0, 5)], 1'b1);
      end else if (pick < 32) begin
        pick = $urandom_range(0, 19);
        len = (pick < 12) ? $urandom_range(1, 5) :
              (pick < 17) ? $urandom_range(6, 8) : $urandom_range(9, 12);
        repeat (len) push_byte(rand_letter(), 1'b0, 1'b1);
      end else if (pick < 52) begin
        pick = $urandom_range(0, 19);
        len = (pick < 14) ? $urandom_range(1, 4) :
              (pick < 18) ? $urandom_range(5, 8) : $urandom_range(9, 16);
        repeat (len) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b1);
      end else if (pick < 70) begin
        push_byte(OP_CHARS[$urandom_range(0, 7)], 1'b0, 1'b1);
      end else if (pick < 92) begin
        push_byte(BLANK_CHARS[$urandom_range(0, 3)], 1'b0, 1'b1);
      end else if (pick < 95) begin
        // any nonzero byte; scanned as whatever it is
        push_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
      end else begin
        // halting byte, then ignored filler and the end of source
        pick = $urandom_range(0, 2);
        c = (pick == 0) ? CH_NUL :
            (pick == 1) ? 8'($urandom_range(128, 255)) : ODD_CHARS[$urandom_range(0, 7)];
        push_byte(c, 1'b0, 1'b1);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        break;
      end
    end
    if (!pending_items[$].eos) begin
      if ($urandom_range(0, 3) == 0) push_byte(BLANK_CHARS[$urandom_range(0, 3)], 1'b1, 1'b1);
      else pending_items[$].eos = 1'b1;
    end
    sources_made++;
    if (sources_made == DRAIN_SOURCE) pending_items[first].drain_first = 1'b1;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("token %0d: %s expected %h, got %h", tokens_seen, field, want, got);
  endtask

  // Source driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tlast  <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata, s_axis_tlast);
        items_accepted++;
      end
      calm = (items_total - items_accepted) < CALM_ITEMS;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain_first && expected_tokens.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          s_axis_tdata  <= next_item.ch;
          s_axis_tlast  <= next_item.eos;
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
        end
      end
    end
  end

  // Token monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          note_mismatch("token text (none expected)", '0, m_axis_tdata[63:0]);
        end else begin
          tok_t want;
          want = expected_tokens.pop_front();
          if (m_axis_tuser !== want.kind) note_mismatch("kind", want.kind, m_axis_tuser);
          if (m_axis_tdata[63:0] !== want.text)
            note_mismatch("text", want.text, m_axis_tdata[63:0]);
          if (m_axis_tdata[67:64] !== want.len)
            note_mismatch("length", want.len, m_axis_tdata[67:64]);
          if (m_axis_tdata[68] !== want.cut)
            note_mismatch("truncated", want.cut, m_axis_tdata[68]);
          if (m_axis_tlast !== want.last) note_mismatch("last", want.last, m_axis_tlast);
        end
        if (tokens_seen == HOLD_AT_TOKEN) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_char_stream_tokenizer: done, errors");
      $finish;
    end
  end

  initial begin
    calm = 1'b0;
    drop_run();

    // Directed: keywords, every operator, blanks, letter and digit extremes
    push_text("let (", 1'b0);
    push_byte(CH_TAB, 1'b0, 1'b0);
    push_text("const)", 1'b0);
    push_text("+-*/!?", 1'b0);
    push_byte(CH_CR, 1'b0, 1'b0);
    // long identifier is cut, then a number that splits after eight digits
    push_text("AZazqwert098765432", 1'b0);
    push_byte(CH_LF, 1'b1, 1'b0);
    // error byte flushes the run and halts; halted bytes are ignored
    push_text("b", 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // zero byte flushes the run and halts until end of source
    push_text("7", 1'b0);
    push_byte(CH_NUL, 1'b0, 1'b0);
    push_byte(8'h55, 1'b1, 1'b0);
    // end of source flushes a pending number
    push_byte("9", 1'b1, 1'b0);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) add_source();
    items_total = pending_items.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < items_total || expected_tokens.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb_char_stream_tokenizer: done, clean");
    end else begin
      $display("tb_char_stream_tokenizer: done, errors");
    end
    $finish;
  end

endmodule
